>>> rtl/spot_pkg.sv
package spot_pkg;

    localparam int RADIUS_BITS = 16;
    localparam int RSUM_BITS   = RADIUS_BITS + 1;
    localparam int MARGIN_BITS = 8;
    localparam int FRAC_SHIFT  = 8;   // Q.4 radius squared gives Q.8

    localparam logic [MARGIN_BITS-1:0] MARGIN_RESET = 8'd4;

    typedef enum logic [1:0] {
        OP_BOX_BOX   = 2'd0,
        OP_CIRC_CIRC = 2'd1,
        OP_BOX_CIRC  = 2'd2,
        OP_CIRC_BOX  = 2'd3
    } t_opcode;

    // load enables for the squaring and compare stages
    typedef struct packed {
        logic s3;
        logic s4;
    } t_stage_en;

endpackage

>>> rtl/spot_sq_cmp.sv
module spot_sq_cmp #(
    parameter int COORD_BITS = 16
) (
    input  logic                                    i_clk,
    input  spot_pkg::t_stage_en                     i_en,
    input  logic [COORD_BITS:0]                     i_dx,
    input  logic [COORD_BITS:0]                     i_dy,
    input  logic [spot_pkg::RSUM_BITS-1:0]          i_radius,
    output logic                                    o_hit
);
    import spot_pkg::*;

    localparam int DIST_BITS = COORD_BITS + 1;
    localparam int SQ_BITS   = 2 * DIST_BITS;
    localparam int LHS_BITS  = SQ_BITS + 1 + FRAC_SHIFT;
    localparam int R2_BITS   = 2 * RSUM_BITS;
    localparam int CMP_BITS  = (LHS_BITS > R2_BITS) ? LHS_BITS : R2_BITS;

    logic [SQ_BITS-1:0]  r_dx2;
    logic [SQ_BITS-1:0]  r_dy2;
    logic [R2_BITS-1:0]  r_r2;
    logic                r_hit;

    logic [SQ_BITS:0]    n_sum;
    logic [CMP_BITS-1:0] n_lhs;
    logic [CMP_BITS-1:0] n_rhs;

    // stage 3: three independent multipliers
    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_dx2 <= i_dx * i_dx;
            r_dy2 <= i_dy * i_dy;
            r_r2  <= i_radius * i_radius;
        end
    end

    // stage 4: sum of squares in Q.8 against radius squared, strict
    always_comb begin
        n_sum = (SQ_BITS+1)'(r_dx2) + (SQ_BITS+1)'(r_dy2);
        n_lhs = CMP_BITS'({n_sum, {FRAC_SHIFT{1'b0}}});
        n_rhs = CMP_BITS'(r_r2);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s4) begin
            r_hit <= (n_lhs < n_rhs);
        end
    end

    assign o_hit = r_hit;

endmodule

>>> rtl/shape_pair_overlap_test.sv
// Shape pair overlap test, four register stages.
// collided comes from the stage 4 registers; an accepted item passes stages 1, 2, 3 and 4 in order.
// Throughput: one item per cycle; each stage advances when it is empty or
// the stage after it moves, so stalls at the output back up stage by stage.
// Reset (synchronous, active low) empties the pipe and sets box_margin to 4.
// The config port is always ready; box_margin is sampled at stage 1.
module shape_pair_overlap_test #(
    parameter int COORD_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,

    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [spot_pkg::MARGIN_BITS-1:0]      i_cfg_data,

    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [1:0]                            i_opcode,
    input  logic signed [COORD_BITS-1:0]          i_a_x,
    input  logic signed [COORD_BITS-1:0]          i_a_y,
    input  logic [COORD_BITS-2:0]                 i_a_w,
    input  logic [COORD_BITS-2:0]                 i_a_h,
    input  logic [spot_pkg::RADIUS_BITS-1:0]      i_a_radius,
    input  logic signed [COORD_BITS-1:0]          i_b_x,
    input  logic signed [COORD_BITS-1:0]          i_b_y,
    input  logic [COORD_BITS-2:0]                 i_b_w,
    input  logic [COORD_BITS-2:0]                 i_b_h,
    input  logic [spot_pkg::RADIUS_BITS-1:0]      i_b_radius,

    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic                                  o_collided
);
    import spot_pkg::*;

    // Working width for coordinates: edges, centres and margin-shifted edges
    // all fit in COORD_BITS+2 signed bits; one extra bit of headroom.
    localparam int EXT_BITS  = COORD_BITS + 3;
    localparam int DIST_BITS = COORD_BITS + 1;

    // ---------------- handshake / pipeline control ----------------
    logic r_v1, r_v2, r_v3, r_v4;
    logic can1, can2, can3, can4;
    t_stage_en sq_en;

    assign can4 = !r_v4 || !i_out_stall;
    assign can3 = !r_v3 || can4;
    assign can2 = !r_v2 || can3;
    assign can1 = !r_v1 || can2;

    assign o_in_stall  = !can1;
    assign o_out_valid = r_v4;
    assign o_cfg_ready = 1'b1;

    assign sq_en.s3 = can3;
    assign sq_en.s4 = can4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (can1) r_v1 <= i_in_valid;
            if (can2) r_v2 <= r_v1;
            if (can3) r_v3 <= r_v2;
            if (can4) r_v4 <= r_v3;
        end
    end

    // ---------------- configuration ----------------
    logic [MARGIN_BITS-1:0] r_box_margin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_margin <= MARGIN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_box_margin <= i_cfg_data;
        end
    end

    // ---------------- stage 1: edges, centres, operand select ----------------
    logic signed [EXT_BITS-1:0] ax, ay, bx, by, aw, ah, bw, bh, mg;
    logic signed [EXT_BITS-1:0] cxa, cya, cxb, cyb, a_re, a_be, b_re, b_be;

    logic signed [EXT_BITS-1:0] n_lo_x, n_hi_x, n_lo_y, n_hi_y, n_cx, n_cy;
    logic [RSUM_BITS-1:0]       n_rad;
    t_opcode                    n_op;

    always_comb begin
        ax  = EXT_BITS'(i_a_x);
        ay  = EXT_BITS'(i_a_y);
        bx  = EXT_BITS'(i_b_x);
        by  = EXT_BITS'(i_b_y);
        aw  = $signed(EXT_BITS'(i_a_w));
        ah  = $signed(EXT_BITS'(i_a_h));
        bw  = $signed(EXT_BITS'(i_b_w));
        bh  = $signed(EXT_BITS'(i_b_h));
        mg  = $signed(EXT_BITS'(r_box_margin));

        // floored half sizes; sizes are nonnegative so a shift floors
        cxa = ax + $signed(EXT_BITS'(i_a_w >> 1));
        cya = ay + $signed(EXT_BITS'(i_a_h >> 1));
        cxb = bx + $signed(EXT_BITS'(i_b_w >> 1));
        cyb = by + $signed(EXT_BITS'(i_b_h >> 1));

        a_re = ax + aw;
        a_be = ay + ah;
        b_re = bx + bw;
        b_be = by + bh;

        n_op = t_opcode'(i_opcode);

        // Circle-circle is a clamp onto a zero-size box at B's centre, so
        // all three round tests share the same clamp / square datapath.
        unique case (n_op) inside
            OP_BOX_CIRC: begin
                n_lo_x = ax;   n_hi_x = a_re;
                n_lo_y = ay;   n_hi_y = a_be;
                n_cx   = cxb;  n_cy   = cyb;
                n_rad  = RSUM_BITS'(i_b_radius);
            end
            OP_CIRC_BOX: begin
                n_lo_x = bx;   n_hi_x = b_re;
                n_lo_y = by;   n_hi_y = b_be;
                n_cx   = cxa;  n_cy   = cya;
                n_rad  = RSUM_BITS'(i_a_radius);
            end
            OP_BOX_BOX, OP_CIRC_CIRC: begin
                n_lo_x = cxb;  n_hi_x = cxb;
                n_lo_y = cyb;  n_hi_y = cyb;
                n_cx   = cxa;  n_cy   = cya;
                n_rad  = RSUM_BITS'(i_a_radius) + RSUM_BITS'(i_b_radius);
            end
            default: begin
                n_lo_x = cxb;  n_hi_x = cxb;
                n_lo_y = cyb;  n_hi_y = cyb;
                n_cx   = cxa;  n_cy   = cya;
                n_rad  = RSUM_BITS'(i_a_radius) + RSUM_BITS'(i_b_radius);
            end
        endcase
    end

    // box-box operands: A's edges pulled in by the margin, B's raw edges
    logic signed [EXT_BITS-1:0] r_s1_a_rm, r_s1_a_lm, r_s1_a_bm, r_s1_a_tm;
    logic signed [EXT_BITS-1:0] r_s1_bx, r_s1_by, r_s1_b_re, r_s1_b_be;
    logic signed [EXT_BITS-1:0] r_s1_lo_x, r_s1_hi_x, r_s1_lo_y, r_s1_hi_y;
    logic signed [EXT_BITS-1:0] r_s1_cx, r_s1_cy;
    logic [RSUM_BITS-1:0]       r_s1_rad;
    logic                       r_s1_is_bb;

    always_ff @(posedge i_clk) begin
        if (can1) begin
            r_s1_a_rm  <= a_re - mg;
            r_s1_a_lm  <= ax + mg;
            r_s1_a_bm  <= a_be - mg;
            r_s1_a_tm  <= ay + mg;
            r_s1_bx    <= bx;
            r_s1_by    <= by;
            r_s1_b_re  <= b_re;
            r_s1_b_be  <= b_be;
            r_s1_lo_x  <= n_lo_x;
            r_s1_hi_x  <= n_hi_x;
            r_s1_lo_y  <= n_lo_y;
            r_s1_hi_y  <= n_hi_y;
            r_s1_cx    <= n_cx;
            r_s1_cy    <= n_cy;
            r_s1_rad   <= n_rad;
            r_s1_is_bb <= (n_op == OP_BOX_BOX);
        end
    end

    // ---------------- stage 2: box compares, clamp, abs distance ----------------
    logic signed [EXT_BITS-1:0] px, py, ddx, ddy, adx, ady;
    logic                       n_bb_hit;

    always_comb begin
        n_bb_hit = (r_s1_a_rm > r_s1_bx) && (r_s1_a_lm < r_s1_b_re) &&
                   (r_s1_a_bm > r_s1_by) && (r_s1_a_tm < r_s1_b_be);

        if (r_s1_cx < r_s1_lo_x)      px = r_s1_lo_x;
        else if (r_s1_cx > r_s1_hi_x) px = r_s1_hi_x;
        else                          px = r_s1_cx;

        if (r_s1_cy < r_s1_lo_y)      py = r_s1_lo_y;
        else if (r_s1_cy > r_s1_hi_y) py = r_s1_hi_y;
        else                          py = r_s1_cy;

        ddx = px - r_s1_cx;
        ddy = py - r_s1_cy;
        adx = ddx[EXT_BITS-1] ? -ddx : ddx;
        ady = ddy[EXT_BITS-1] ? -ddy : ddy;
    end

    logic [DIST_BITS-1:0] r_s2_dx, r_s2_dy;
    logic [RSUM_BITS-1:0] r_s2_rad;
    logic                 r_s2_is_bb, r_s2_bb_hit;

    always_ff @(posedge i_clk) begin
        if (can2) begin
            r_s2_dx     <= adx[DIST_BITS-1:0];
            r_s2_dy     <= ady[DIST_BITS-1:0];
            r_s2_rad    <= r_s1_rad;
            r_s2_is_bb  <= r_s1_is_bb;
            r_s2_bb_hit <= n_bb_hit;
        end
    end

    // ---------------- stages 3 and 4: squares and final compare ----------------
    logic round_hit;

    spot_sq_cmp #(
        .COORD_BITS (COORD_BITS)
    ) u_sq_cmp (
        .i_clk    (i_clk),
        .i_en     (sq_en),
        .i_dx     (r_s2_dx),
        .i_dy     (r_s2_dy),
        .i_radius (r_s2_rad),
        .o_hit    (round_hit)
    );

    logic r_s3_is_bb, r_s3_bb_hit, r_s4_is_bb, r_s4_bb_hit;

    always_ff @(posedge i_clk) begin
        if (can3) begin
            r_s3_is_bb  <= r_s2_is_bb;
            r_s3_bb_hit <= r_s2_bb_hit;
        end
        if (can4) begin
            r_s4_is_bb  <= r_s3_is_bb;
            r_s4_bb_hit <= r_s3_bb_hit;
        end
    end

    assign o_collided = r_s4_is_bb ? r_s4_bb_hit : round_hit;

    // ---------------- checks ----------------
    // input side stalls only when every stage holds an item
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_v1 && r_v2 && r_v3 && r_v4 && i_out_stall))
        else $error("input stalled with a free stage");

    // an accepted item lands in stage 1
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_v1)
        else $error("accepted item lost at stage 1");

    // a stage 3 item moves to stage 4 whenever stage 4 can take it
    a_s3_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && can4) |=> r_v4)
        else $error("stage 3 item dropped");

    // margin write takes effect on the next cycle
    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready) |=> (r_box_margin == $past(i_cfg_data)))
        else $error("box_margin not updated");

endmodule
